FILE: hdl/bgd_pkg.sv
// Shared constants, payload structs and state types for the GBRG 5x5 demosaic.
// Used by every module of the block; depends on nothing.
package bgd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int LINES       = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN         = 5;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = 12;
    localparam int WIDTH_W  = 11;
    localparam int SHIFT_W  = 4;
    localparam int GAIN_W   = 12;
    localparam int BANK_W   = $clog2(LINES);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);

    localparam int KW      = SAMPLE_BITS + 6;
    localparam int PW      = KW + GAIN_W + 1;
    localparam int FULL_W  = 21;
    localparam logic [FULL_W-1:0] FULL_SCALE = FULL_W'(1023 * 2048);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SHIFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN    = 3'd5;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] sample;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_row;
        logic       end_of_frame;
    } out_t;

    typedef struct packed {
        logic [COL_W-1:0]   w_m1;
        logic [ROW_W-1:0]   h_m1;
        logic [SHIFT_W-1:0] shift;
        logic [GAIN_W-1:0]  red_gain;
        logic [GAIN_W-1:0]  green_gain;
        logic [GAIN_W-1:0]  blue_gain;
    } cfg_t;

    typedef enum logic {
        CMD_SAMPLE,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [SAMPLE_BITS-1:0] value;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic                   emit;
        logic                   triple;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_EMIT,
        ST_DRD,
        ST_DLAST,
        ST_DEMIT
    } state_t;

endpackage

FILE: hdl/bgd_front.sv
// Front end: accepts input requests, tracks raster position and turns each
// in-frame sample and later drain into a back-end command. Depends on bgd_pkg.
module bgd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  bgd_pkg::cfg_t cfg,
    input  logic          restart,
    input  logic          src_valid,
    output logic          src_ready,
    input  bgd_pkg::in_t  src_data,
    input  logic          cmd_full,
    output logic          cmd_push,
    output bgd_pkg::cmd_t cmd_data
);

    localparam int SB    = bgd_pkg::SAMPLE_BITS;
    localparam int COL_W = bgd_pkg::COL_W;
    localparam int ROW_W = bgd_pkg::ROW_W;

    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic accept, sample_ok, drain_ok, emit, triple;

    always_comb
    begin
        accept    = src_valid && !cmd_full;
        sample_ok = (src_data.action == bgd_pkg::ACT_SAMPLE) && (in_row_reg <= cfg.h_m1);
        drain_ok  = (src_data.action == bgd_pkg::ACT_DRAIN) && (in_row_reg > cfg.h_m1);
        emit      = (in_row_reg >= ROW_W'(2)) && (in_col_reg >= COL_W'(2));
        triple    = (in_col_reg == cfg.w_m1);

        cmd_data.kind   = sample_ok ? bgd_pkg::CMD_SAMPLE : bgd_pkg::CMD_DRAIN;
        cmd_data.value  = SB'(src_data.sample[SB-1:0] >> cfg.shift);
        cmd_data.row    = sample_ok ? in_row_reg : out_row_reg;
        cmd_data.col    = sample_ok ? in_col_reg : out_col_reg;
        cmd_data.emit   = emit;
        cmd_data.triple = triple;
        cmd_push        = accept && (sample_ok || drain_ok);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept && sample_ok)
        begin
            if (triple)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit)
            begin
                if (triple)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
        else if (accept && drain_ok)
        begin
            if (out_col_reg == cfg.w_m1)
            begin
                out_col_next = '0;
                if (out_row_reg == cfg.h_m1)
                begin
                    out_row_next = '0;
                    in_col_next  = '0;
                    in_row_next  = '0;
                end
                else
                begin
                    out_row_next = out_row_reg + ROW_W'(1);
                end
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    assign src_ready = !cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (restart)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

FILE: hdl/bgd_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on bgd_pkg.
module bgd_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bgd_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output bgd_pkg::cmd_t head
);

    localparam int DEPTH = bgd_pkg::CMD_DEPTH;
    localparam int PTR_W = bgd_pkg::CMD_PTR_W;

    bgd_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    always_comb
    begin
        full       = (count_reg == (PTR_W+1)'(DEPTH));
        head_valid = (count_reg != '0);
        head       = entry_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

FILE: hdl/bgd_back.sv
// Back end: line stores, 5x5 window, kernel, gains and 8-bit mapping.
// Executes commands from the queue; depends on bgd_pkg.
module bgd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  bgd_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    input  bgd_pkg::cmd_t cmd_head,
    output logic          cmd_pop,
    output logic          dst_valid,
    input  logic          dst_ready,
    output bgd_pkg::out_t dst_data
);

    localparam int SB     = bgd_pkg::SAMPLE_BITS;
    localparam int WIN    = bgd_pkg::WIN;
    localparam int LINES  = bgd_pkg::LINES;
    localparam int COL_W  = bgd_pkg::COL_W;
    localparam int ROW_W  = bgd_pkg::ROW_W;
    localparam int BANK_W = bgd_pkg::BANK_W;
    localparam int KW     = bgd_pkg::KW;
    localparam int PW     = bgd_pkg::PW;
    localparam int FULL_W = bgd_pkg::FULL_W;
    localparam int X_W    = FULL_W + 8 - 11 + 1;

    typedef struct packed {
        logic odd_r;
        logic odd_c;
        logic eor;
        logic eof;
    } tag_t;

    logic [SB-1:0] line_mem [LINES][bgd_pkg::MAX_WIDTH];
    logic [SB-1:0] rdata_reg [LINES];
    logic [SB-1:0] win_reg [WIN][WIN];
    logic [SB-1:0] dwin_reg [WIN][WIN];
    logic [SB-1:0] n_reg [WIN][WIN];
    logic [SB-1:0] n_next [WIN][WIN];
    logic [SB-1:0] win_col [WIN];
    logic [2:0]    slot [WIN];
    logic [BANK_W-1:0] drow_bank [WIN];

    bgd_pkg::state_t state_reg, state_next;
    bgd_pkg::cmd_t   cmd_reg;
    logic [1:0] pix_reg, pix_next;
    logic [2:0] step_reg, step_next;
    logic       cap_reg;
    logic [2:0] cap_idx_reg;

    logic mem_re, mem_we, load_n, adv, last_pix;
    logic [COL_W-1:0] mem_addr, emit_col, dcol;
    logic [ROW_W-1:0] prow;
    logic [COL_W-1:0] pcol;
    tag_t tag_next;

    logic nv_reg, kv_reg, pv_reg, dst_valid_reg;
    tag_t n_tag_reg, k_tag_reg, p_tag_reg;
    logic signed [KW-1:0] kr_next, kg_next, kb_next, kr_reg, kg_reg, kb_reg;
    logic signed [PW-1:0] pr_reg, pg_reg, pb_reg;
    bgd_pkg::out_t out_reg;

    function automatic logic [7:0] to8(input logic signed [PW-1:0] p);
        logic [FULL_W-1:0]   pc;
        logic [FULL_W+7:0]   m;
        logic [X_W-1:0]      x;
        logic [X_W-11:0]     q0;
        logic [10:0]         r;
        logic [X_W-10:0]     q;
        if (p < 0)
        begin
            pc = '0;
        end
        else if (p > $signed({1'b0, bgd_pkg::FULL_SCALE}))
        begin
            pc = bgd_pkg::FULL_SCALE;
        end
        else
        begin
            pc = p[FULL_W-1:0];
        end
        m  = ({pc, 8'd0} - (FULL_W+8)'(pc));
        x  = X_W'(m >> 11) + X_W'(511);
        q0 = x[X_W-1:10];
        r  = 11'(x[9:0]) + 11'(q0);
        q  = (r >= 11'd1023) ? ((X_W-9)'(q0) + (X_W-9)'(1)) : (X_W-9)'(q0);
        return q[7:0];
    endfunction

    assign adv = !dst_valid_reg || dst_ready;

    always_comb
    begin
        logic [COL_W:0]   cj;
        logic [COL_W:0]   cv;
        logic [COL_W-1:0] colv;
        logic [COL_W+1:0] t;
        logic [COL_W+1:0] d;
        logic [ROW_W:0]   rk;
        logic [ROW_W-1:0] kk;
        logic [COL_W:0]   dc;

        case (pix_reg)
            2'd0:    emit_col = cmd_reg.col - COL_W'(2);
            2'd1:    emit_col = cfg.w_m1 - COL_W'(1);
            default: emit_col = cfg.w_m1;
        endcase

        for (int j = 0; j < WIN; j++)
        begin
            cj = {1'b0, emit_col} + (COL_W+1)'(j);
            cv = (cj < (COL_W+1)'(2)) ? '0 : cj - (COL_W+1)'(2);
            if (cv > {1'b0, cfg.w_m1})
            begin
                cv = {1'b0, cfg.w_m1};
            end
            colv = cv[COL_W-1:0];
            t = {2'b00, colv} + (COL_W+2)'(4);
            if (t < {2'b00, cmd_reg.col})
            begin
                slot[j] = 3'd0;
            end
            else
            begin
                d = t - {2'b00, cmd_reg.col};
                slot[j] = (d > (COL_W+2)'(4)) ? 3'd4 : d[2:0];
            end
        end

        for (int i = 0; i < WIN; i++)
        begin
            rk = {1'b0, cmd_reg.row} + (ROW_W+1)'(i);
            kk = (rk < (ROW_W+1)'(4)) ? '0 : ROW_W'(rk - (ROW_W+1)'(4));
            win_col[i] = (kk == cmd_reg.row) ? cmd_reg.value : rdata_reg[kk[BANK_W-1:0]];

            rk = {1'b0, cmd_reg.row} + (ROW_W+1)'(i);
            rk = (rk < (ROW_W+1)'(2)) ? '0 : rk - (ROW_W+1)'(2);
            if (rk > {1'b0, cfg.h_m1})
            begin
                rk = {1'b0, cfg.h_m1};
            end
            drow_bank[i] = rk[BANK_W-1:0];
        end

        dc = {1'b0, cmd_reg.col} + (COL_W+1)'(step_reg);
        dc = (dc < (COL_W+1)'(2)) ? '0 : dc - (COL_W+1)'(2);
        if (dc > {1'b0, cfg.w_m1})
        begin
            dc = {1'b0, cfg.w_m1};
        end
        dcol = dc[COL_W-1:0];

        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                n_next[i][j] = (state_reg == bgd_pkg::ST_DEMIT) ? dwin_reg[i][j]
                                                               : win_reg[i][slot[j]];
            end
        end

        prow = (cmd_reg.kind == bgd_pkg::CMD_DRAIN) ? cmd_reg.row : cmd_reg.row - ROW_W'(2);
        pcol = (cmd_reg.kind == bgd_pkg::CMD_DRAIN) ? cmd_reg.col : emit_col;
        tag_next.odd_r = prow[0];
        tag_next.odd_c = pcol[0];
        tag_next.eor   = (pcol == cfg.w_m1);
        tag_next.eof   = (pcol == cfg.w_m1) && (prow == cfg.h_m1);
        last_pix = cmd_reg.triple ? (pix_reg == 2'd2) : 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bgd_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd_head.kind == bgd_pkg::CMD_SAMPLE) ? bgd_pkg::ST_WIN
                                                                        : bgd_pkg::ST_DRD;
                end
            end
            bgd_pkg::ST_WIN:
            begin
                state_next = cmd_reg.emit ? bgd_pkg::ST_EMIT : bgd_pkg::ST_IDLE;
            end
            bgd_pkg::ST_EMIT:
            begin
                if (adv && last_pix)
                begin
                    state_next = bgd_pkg::ST_IDLE;
                end
            end
            bgd_pkg::ST_DRD:
            begin
                if (step_reg == 3'd4)
                begin
                    state_next = bgd_pkg::ST_DLAST;
                end
            end
            bgd_pkg::ST_DLAST:
            begin
                state_next = bgd_pkg::ST_DEMIT;
            end
            bgd_pkg::ST_DEMIT:
            begin
                if (adv)
                begin
                    state_next = bgd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bgd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = cmd_head.col;
        load_n    = 1'b0;
        pix_next  = pix_reg;
        step_next = step_reg;
        case (state_reg)
            bgd_pkg::ST_IDLE:
            begin
                cmd_pop   = cmd_valid;
                mem_re    = cmd_valid && (cmd_head.kind == bgd_pkg::CMD_SAMPLE);
                mem_we    = cmd_valid && (cmd_head.kind == bgd_pkg::CMD_SAMPLE);
                pix_next  = 2'd0;
                step_next = 3'd0;
            end
            bgd_pkg::ST_EMIT:
            begin
                load_n = adv;
                if (adv)
                begin
                    pix_next = pix_reg + 2'd1;
                end
            end
            bgd_pkg::ST_DRD:
            begin
                mem_re    = 1'b1;
                mem_addr  = dcol;
                step_next = step_reg + 3'd1;
            end
            bgd_pkg::ST_DEMIT:
            begin
                load_n = adv;
            end
            default:
            begin
                load_n = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < LINES; b++)
        begin
            if (mem_we && (cmd_head.row[BANK_W-1:0] == BANK_W'(b)))
            begin
                line_mem[b][mem_addr] <= cmd_head.value;
            end
            if (mem_re)
            begin
                rdata_reg[b] <= line_mem[b][mem_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_head;
        end
        if (state_reg == bgd_pkg::ST_WIN)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                for (int j = 0; j < WIN - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][WIN-1] <= win_col[i];
            end
        end
        if (cap_reg)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                dwin_reg[i][cap_idx_reg] <= rdata_reg[drow_bank[i]];
            end
        end
        if (load_n)
        begin
            n_reg     <= n_next;
            n_tag_reg <= tag_next;
        end
        if (adv)
        begin
            kr_reg    <= kr_next;
            kg_reg    <= kg_next;
            kb_reg    <= kb_next;
            k_tag_reg <= n_tag_reg;
            pr_reg    <= kr_reg * $signed({1'b0, cfg.red_gain});
            pg_reg    <= kg_reg * $signed({1'b0, cfg.green_gain});
            pb_reg    <= kb_reg * $signed({1'b0, cfg.blue_gain});
            p_tag_reg <= k_tag_reg;
            out_reg.red          <= to8(pr_reg);
            out_reg.green        <= to8(pg_reg);
            out_reg.blue         <= to8(pb_reg);
            out_reg.end_of_row   <= p_tag_reg.eor;
            out_reg.end_of_frame <= p_tag_reg.eof;
        end
    end

    always_comb
    begin
        logic signed [KW-1:0] e [WIN][WIN];
        logic signed [KW-1:0] ctr, v1, h1, v2, h2, dg, c1, c2;
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                e[i][j] = $signed(KW'(n_reg[i][j]));
            end
        end
        ctr = e[2][2] <<< 3;
        v1  = e[1][2] + e[3][2];
        h1  = e[2][1] + e[2][3];
        v2  = e[0][2] + e[4][2];
        h2  = e[2][0] + e[2][4];
        dg  = e[1][1] + e[1][3] + e[3][1] + e[3][3];
        c1  = v1 + h1;
        c2  = v2 + h2;
        case ({n_tag_reg.odd_r, n_tag_reg.odd_c})
            2'b10:
            begin
                kr_next = ctr;
                kg_next = ctr + (c1 <<< 1) - c2;
                kb_next = ctr + (dg <<< 1) - c2;
            end
            2'b01:
            begin
                kb_next = ctr;
                kg_next = ctr + (c1 <<< 1) - c2;
                kr_next = ctr + (dg <<< 1) - c2;
            end
            2'b00:
            begin
                kg_next = ctr;
                kr_next = ctr + (v1 <<< 1) - v2;
                kb_next = ctr + (h1 <<< 1) - h2;
            end
            default:
            begin
                kg_next = ctr;
                kr_next = ctr + (h1 <<< 1) - h2;
                kb_next = ctr + (v1 <<< 1) - v2;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bgd_pkg::ST_IDLE;
            pix_reg       <= '0;
            step_reg      <= '0;
            cap_reg       <= 1'b0;
            cap_idx_reg   <= '0;
            nv_reg        <= 1'b0;
            kv_reg        <= 1'b0;
            pv_reg        <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pix_reg     <= pix_next;
            step_reg    <= step_next;
            cap_reg     <= (state_reg == bgd_pkg::ST_DRD);
            cap_idx_reg <= step_reg;
            if (adv)
            begin
                nv_reg        <= load_n;
                kv_reg        <= nv_reg;
                pv_reg        <= kv_reg;
                dst_valid_reg <= pv_reg;
            end
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = out_reg;

    a_emit_is_sample: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bgd_pkg::ST_EMIT |-> cmd_reg.kind == bgd_pkg::CMD_SAMPLE && cmd_reg.emit)
        else $error("pixel emission without a pending sample");

    a_capture_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg |-> $past(state_reg == bgd_pkg::ST_DRD))
        else $error("drain capture without a preceding read");

    a_demit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bgd_pkg::ST_DEMIT |->
            $past(state_reg == bgd_pkg::ST_DLAST) || $past(state_reg == bgd_pkg::ST_DEMIT))
        else $error("drain emission entered before the window was filled");

    a_single_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bgd_pkg::ST_EMIT && !cmd_reg.triple |-> pix_reg == 2'd0)
        else $error("extra pixel emitted for a mid-row sample");

endmodule

FILE: hdl/bayer_gbrg_demosaic_5x5_top.sv
// Top level of the GBRG 5x5 demosaic: configuration registers and the
// front end, command queue and back end. Depends on bgd_pkg and its modules.
//
// Raw samples enter on the src channel in raster order (action sample); each
// accepted request may yield up to three RGB pixels on the dst channel. Output
// lags the input by two rows; after the last sample of a frame, drain requests
// release the last two rows one pixel each.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must
// write it only while idle, as the block has no check for this. Writing the
// frame width or height restarts the frame. A sample's pixels pass through the
// neighbourhood, kernel, gain and output registers; at a row end the two extra
// pixels follow the first. The back end takes one command at a time: a sample
// is written to the line store and shifted into the window, then each of its
// pixels is emitted; a drain request reads its window columns one by one, set
// by the single read port of each of the four line-store banks, then emits
// one pixel. A four-entry command queue lets the input side run ahead of it.
// Reset restores the default registers and clears all counters and valid
// flags; line-store contents are not cleared and need no clearing pass.
// When dst_ready is low the output register holds its pixel, the pipeline
// stops, and the queue fills before src_ready drops.
module bayer_gbrg_demosaic_5x5_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    output logic                              src_ready,
    input  bgd_pkg::in_t                      src_data,
    output logic                              dst_valid,
    input  logic                              dst_ready,
    output bgd_pkg::out_t                     dst_data,
    input  logic                              cfg_write,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bgd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W = bgd_pkg::COL_W;
    localparam int ROW_W = bgd_pkg::ROW_W;

    logic [bgd_pkg::WIDTH_W-1:0] frame_width_reg;
    logic [ROW_W-1:0]            frame_height_reg;
    logic [bgd_pkg::SHIFT_W-1:0] pixel_shift_reg;
    logic [bgd_pkg::GAIN_W-1:0]  red_gain_reg, green_gain_reg, blue_gain_reg;

    bgd_pkg::cfg_t cfg;
    bgd_pkg::cmd_t push_cmd, head_cmd;
    logic restart, cmd_push, cmd_full, cmd_pop, head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 11'd640;
            frame_height_reg <= 12'd480;
            pixel_shift_reg  <= 4'd0;
            red_gain_reg     <= 12'd1280;
            green_gain_reg   <= 12'd1152;
            blue_gain_reg    <= 12'd1229;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bgd_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[bgd_pkg::WIDTH_W-1:0];
                bgd_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[ROW_W-1:0];
                bgd_pkg::REG_PIXEL_SHIFT:  pixel_shift_reg  <= cfg_data[bgd_pkg::SHIFT_W-1:0];
                bgd_pkg::REG_RED_GAIN:     red_gain_reg     <= cfg_data[bgd_pkg::GAIN_W-1:0];
                bgd_pkg::REG_GREEN_GAIN:   green_gain_reg   <= cfg_data[bgd_pkg::GAIN_W-1:0];
                bgd_pkg::REG_BLUE_GAIN:    blue_gain_reg    <= cfg_data[bgd_pkg::GAIN_W-1:0];
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg < 11'd3)
        begin
            cfg.w_m1 = COL_W'(2);
        end
        else if (frame_width_reg > bgd_pkg::MAX_WIDTH)
        begin
            cfg.w_m1 = COL_W'(bgd_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            cfg.w_m1 = COL_W'(frame_width_reg - 11'd1);
        end
        cfg.h_m1       = (frame_height_reg < 12'd3) ? 12'd2 : frame_height_reg - 12'd1;
        cfg.shift      = pixel_shift_reg;
        cfg.red_gain   = red_gain_reg;
        cfg.green_gain = green_gain_reg;
        cfg.blue_gain  = blue_gain_reg;
        restart = cfg_write && ((cfg_index == bgd_pkg::REG_FRAME_WIDTH) ||
                                (cfg_index == bgd_pkg::REG_FRAME_HEIGHT));
    end

    bgd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .restart   (restart),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_data  (push_cmd)
    );

    bgd_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (push_cmd),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head       (head_cmd)
    );

    bgd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (head_valid),
        .cmd_head  (head_cmd),
        .cmd_pop   (cmd_pop),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the GBRG 5x5 demosaic top level.
// Drives raw and drain requests through valid/ready, predicts each pixel in
// SystemVerilog and compares it with the block's output. Depends on bgd_pkg.
module tb_top;

    typedef enum int { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t                                kind;
        logic [bgd_pkg::CFG_IDX_W-1:0]            idx;
        logic [bgd_pkg::CFG_DATA_W-1:0]           data;
        logic                                     action;
        logic [15:0]                              sample;
        int                                       reps;
        bit                                       fixed;
        logic [23:0]                              rgb;
    } row_t;

    typedef struct {
        bgd_pkg::in_t d;
        bit           fixed;
        logic [23:0]  rgb;
    } request_t;

    logic clk;
    logic rst_n;
    logic src_valid;
    logic src_ready;
    bgd_pkg::in_t src_data;
    logic dst_valid;
    logic dst_ready;
    bgd_pkg::out_t dst_data;
    logic cfg_write;
    logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bgd_pkg::CFG_DATA_W-1:0] cfg_data;

    request_t pending_requests[$];
    request_t active_request;
    bgd_pkg::out_t expected_pixels[$];
    int errors;
    int accepted_requests;
    int cycle_count;
    int burst_left;
    int gap_left;
    int max_gap;
    int stall_pct;
    int hold_left;
    bit hold_request;

    int model_width, model_height, model_shift;
    int model_red_gain, model_green_gain, model_blue_gain;
    logic [15:0] line_mem[bgd_pkg::LINES*bgd_pkg::MAX_WIDTH];
    logic [15:0] window_reg[5][5];
    int in_col, in_row, out_col, out_row;
    int nbr[5][5];

    row_t dir_tab[] = '{
        '{ROW_CFG, bgd_pkg::REG_FRAME_WIDTH, 12'd2, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_CFG, bgd_pkg::REG_FRAME_HEIGHT, 12'd0, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_CFG, bgd_pkg::REG_PIXEL_SHIFT, 12'd0, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_ITEM, bgd_pkg::REG_FRAME_WIDTH, 12'd0, bgd_pkg::ACT_DRAIN, 16'h0, 1, 1'b0,
          24'h0},
        '{ROW_ITEM, bgd_pkg::REG_FRAME_WIDTH, 12'd0, bgd_pkg::ACT_SAMPLE, 16'hFFFF, 9, 1'b1,
          24'hFFFFFF},
        '{ROW_ITEM, bgd_pkg::REG_FRAME_WIDTH, 12'd0, bgd_pkg::ACT_SAMPLE, 16'h0000, 1, 1'b0,
          24'h0},
        '{ROW_ITEM, bgd_pkg::REG_FRAME_WIDTH, 12'd0, bgd_pkg::ACT_DRAIN, 16'h0, 6, 1'b1,
          24'hFFFFFF},
        '{ROW_CFG, bgd_pkg::REG_RED_GAIN, 12'd0, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_CFG, bgd_pkg::REG_GREEN_GAIN, 12'd4095, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_CFG, bgd_pkg::REG_BLUE_GAIN, 12'd0, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_CFG, bgd_pkg::REG_PIXEL_SHIFT, 12'd15, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_CFG, bgd_pkg::REG_FRAME_WIDTH, 12'd4, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_CFG, bgd_pkg::REG_FRAME_HEIGHT, 12'd3, 1'b0, 16'h0, 1, 1'b0, 24'h0},
        '{ROW_ITEM, bgd_pkg::REG_FRAME_WIDTH, 12'd0, bgd_pkg::ACT_SAMPLE, 16'h8000, 2, 1'b0,
          24'h0},
        '{ROW_ITEM, bgd_pkg::REG_FRAME_WIDTH, 12'd0, bgd_pkg::ACT_SAMPLE, 16'h7FFF, 2, 1'b0,
          24'h0}
    };

    bayer_gbrg_demosaic_5x5_top DUT (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_ready(src_ready), .src_data(src_data),
        .dst_valid(dst_valid), .dst_ready(dst_ready), .dst_data(dst_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int eff_width();
        if (model_width < 3) return 3;
        if (model_width > bgd_pkg::MAX_WIDTH) return bgd_pkg::MAX_WIDTH;
        return model_width;
    endfunction

    function automatic int eff_height();
        return (model_height < 3) ? 3 : model_height;
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [7:0] scale_to_8(int k, int gain);
        longint p;
        p = longint'(k) * longint'(gain);
        if (p < 0) p = 0;
        if (p > 2095104) p = 2095104;
        return 8'((p * 255 + 511 * 2048) / 2095104);
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void predictor_reset();
        model_width = 640;
        model_height = 480;
        model_shift = 0;
        model_red_gain = 1280;
        model_green_gain = 1152;
        model_blue_gain = 1229;
        foreach (window_reg[i, j]) window_reg[i][j] = '0;
        restart_frame();
    endfunction

    function automatic void predictor_config(logic [bgd_pkg::CFG_IDX_W-1:0] idx,
                                             logic [bgd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            bgd_pkg::REG_FRAME_WIDTH:
            begin
                model_width = int'(val[10:0]);
                restart_frame();
            end
            bgd_pkg::REG_FRAME_HEIGHT:
            begin
                model_height = int'(val);
                restart_frame();
            end
            bgd_pkg::REG_PIXEL_SHIFT: model_shift = int'(val[3:0]);
            bgd_pkg::REG_RED_GAIN: model_red_gain = int'(val);
            bgd_pkg::REG_GREEN_GAIN: model_green_gain = int'(val);
            bgd_pkg::REG_BLUE_GAIN: model_blue_gain = int'(val);
            default: ;
        endcase
    endfunction

    function automatic void expect_pixel(int r, int c, int w, int h, request_t rq);
        int ctr, vert1, horz1, vert2, horz2, diag, cross1, cross2;
        int kr, kg, kb;
        bgd_pkg::out_t px;
        ctr = 8 * nbr[2][2];
        vert1 = nbr[1][2] + nbr[3][2];
        horz1 = nbr[2][1] + nbr[2][3];
        vert2 = nbr[0][2] + nbr[4][2];
        horz2 = nbr[2][0] + nbr[2][4];
        diag = nbr[1][1] + nbr[1][3] + nbr[3][1] + nbr[3][3];
        cross1 = vert1 + horz1;
        cross2 = vert2 + horz2;
        if (r[0] && !c[0])
        begin
            kr = ctr;
            kg = ctr + 2 * cross1 - cross2;
            kb = ctr + 2 * diag - cross2;
        end
        else if (!r[0] && c[0])
        begin
            kb = ctr;
            kg = ctr + 2 * cross1 - cross2;
            kr = ctr + 2 * diag - cross2;
        end
        else if (!r[0])
        begin
            kg = ctr;
            kr = ctr + 2 * vert1 - vert2;
            kb = ctr + 2 * horz1 - horz2;
        end
        else
        begin
            kg = ctr;
            kr = ctr + 2 * horz1 - horz2;
            kb = ctr + 2 * vert1 - vert2;
        end
        px.red = scale_to_8(kr, model_red_gain);
        px.green = scale_to_8(kg, model_green_gain);
        px.blue = scale_to_8(kb, model_blue_gain);
        if (rq.fixed) {px.red, px.green, px.blue} = rq.rgb;
        px.end_of_row = (c == w - 1);
        px.end_of_frame = (c == w - 1) && (r == h - 1);
        expected_pixels.insert(expected_pixels.size(), px);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
    endfunction

    function automatic void demosaic_step(request_t rq);
        int w, h, ir, ic, k, col, slot, base, ncols;
        int cols[3];
        logic [15:0] v, s;
        w = eff_width();
        h = eff_height();
        if (rq.d.action == bgd_pkg::ACT_DRAIN)
        begin
            if (in_row < h || out_row >= h) return;
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5; j++)
                    nbr[i][j] = line_mem[(clip(out_row - 2 + i, 0, h - 1) % bgd_pkg::LINES)
                                         * bgd_pkg::MAX_WIDTH
                                         + clip(out_col - 2 + j, 0, w - 1)];
            expect_pixel(out_row, out_col, w, h, rq);
            if (out_row >= h) restart_frame();
            return;
        end
        if (in_row >= h) return;
        ir = in_row;
        ic = in_col;
        v = rq.d.sample >> model_shift;
        for (int i = 0; i < 5; i++)
        begin
            k = ir - 4 + i;
            if (k < 0) k = 0;
            s = (k == ir) ? v : line_mem[(k % bgd_pkg::LINES) * bgd_pkg::MAX_WIDTH + ic];
            for (int j = 0; j < 4; j++) window_reg[i][j] = window_reg[i][j + 1];
            window_reg[i][4] = s;
        end
        line_mem[(ir % bgd_pkg::LINES) * bgd_pkg::MAX_WIDTH + ic] = v;
        if (ir >= 2 && ic >= 2)
        begin
            ncols = 1;
            cols[0] = ic - 2;
            if (ic == w - 1)
            begin
                cols[1] = w - 2;
                cols[2] = w - 1;
                ncols = 3;
            end
            base = ic - 4;
            for (int q = 0; q < ncols; q++)
            begin
                for (int j = 0; j < 5; j++)
                begin
                    col = clip(cols[q] - 2 + j, 0, w - 1);
                    slot = clip(col - base, 0, 4);
                    for (int i = 0; i < 5; i++) nbr[i][j] = window_reg[i][slot];
                end
                expect_pixel(ir - 2, cols[q], w, h, rq);
            end
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sender: bursts of requests separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && src_ready)
            begin
                demosaic_step(active_request);
                accepted_requests++;
            end
            if (!src_valid || src_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    src_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    active_request = pending_requests.pop_front();
                    src_valid <= 1'b1;
                    src_data <= active_request.d;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
                    end
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dst_ready <= 1'b0;
            end
            else
                dst_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && dst_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, actual %h", $time, dst_data);
                errors++;
            end
            else if (dst_data !== expected_pixels[0])
            begin
                $display("%0t: pixel mismatch, expected %h, actual %h",
                         $time, expected_pixels[0], dst_data);
                errors++;
                void'(expected_pixels.pop_front());
            end
            else
                void'(expected_pixels.pop_front());
        end
    end

    task automatic wait_idle();
        int waited;
        waited = 0;
        while ((pending_requests.size() > 0 || src_valid || expected_pixels.size() > 0)
               && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [bgd_pkg::CFG_IDX_W-1:0] idx,
                             logic [bgd_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        predictor_config(idx, val);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_request(logic act, logic [15:0] smp);
        request_t rq;
        rq.d.action = act;
        rq.d.sample = smp;
        rq.fixed = 1'b0;
        rq.rgb = '0;
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    task automatic random_gains();
        write_reg(bgd_pkg::REG_RED_GAIN,
                  ($urandom_range(0, 5) == 0) ? 12'd4095 : 12'($urandom));
        write_reg(bgd_pkg::REG_GREEN_GAIN,
                  ($urandom_range(0, 5) == 0) ? 12'd0 : 12'($urandom));
        write_reg(bgd_pkg::REG_BLUE_GAIN, 12'($urandom_range(0, 2048)));
        write_reg(bgd_pkg::REG_PIXEL_SHIFT,
                  ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'd0);
    endtask

    task automatic queue_frame(int w, int h, bit noisy);
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                queue_request(bgd_pkg::ACT_DRAIN, 16'($urandom));
            queue_request(bgd_pkg::ACT_SAMPLE, 16'($urandom));
        end
        for (int i = 0; i < 2 * w; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                queue_request(bgd_pkg::ACT_SAMPLE, 16'($urandom));
            queue_request(bgd_pkg::ACT_DRAIN, 16'($urandom));
        end
    endtask

    initial
    begin
        request_t rq;
        int w, h;
        int cnt;
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_data = '0;
        dst_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        accepted_requests = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        max_gap = 0;
        stall_pct = 0;
        hold_left = 0;
        hold_request = 1'b0;
        predictor_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r])
        begin
            if (dir_tab[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(dir_tab[r].idx, dir_tab[r].data);
            end
            else
            begin
                for (int n = 0; n < dir_tab[r].reps; n++)
                begin
                    rq.d.action = dir_tab[r].action;
                    rq.d.sample = dir_tab[r].sample;
                    rq.fixed = dir_tab[r].fixed;
                    rq.rgb = dir_tab[r].rgb;
                    pending_requests.insert(pending_requests.size(), rq);
                end
            end
        end

        // Widest frame: width beyond the maximum acts as the maximum; only the
        // start of its first row is sent before the next size write.
        wait_idle();
        write_reg(bgd_pkg::REG_FRAME_WIDTH, 12'd2047);
        write_reg(bgd_pkg::REG_FRAME_HEIGHT, 12'd3);
        random_gains();
        for (int i = 0; i < 60; i++) queue_request(bgd_pkg::ACT_SAMPLE, 16'($urandom));

        // Tallest frame, cut short by a later size write.
        wait_idle();
        write_reg(bgd_pkg::REG_FRAME_WIDTH, 12'd3);
        write_reg(bgd_pkg::REG_FRAME_HEIGHT, 12'd4095);
        for (int i = 0; i < 15; i++) queue_request(bgd_pkg::ACT_SAMPLE, 16'($urandom));

        max_gap = 4;
        stall_pct = 30;
        hold_request = 1'b1;
        while (accepted_requests < 500)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:
                begin
                    max_gap = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    max_gap = 3;
                    stall_pct = 20;
                end
                2:
                begin
                    max_gap = 8;
                    stall_pct = 70;
                end
                default:
                begin
                    max_gap = 1;
                    stall_pct = 50;
                end
            endcase
            w = $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            write_reg(bgd_pkg::REG_FRAME_WIDTH,
                      ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2)) : 12'(w));
            write_reg(bgd_pkg::REG_FRAME_HEIGHT,
                      ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2)) : 12'(h));
            w = eff_width();
            h = eff_height();
            random_gains();
            if ($urandom_range(0, 5) == 0)
            begin
                cnt = $urandom_range(1, 3 * w);
                for (int i = 0; i < cnt; i++)
                    queue_request(1'($urandom), 16'($urandom));
            end
            else
                queue_frame(w, h, $urandom_range(0, 3) == 0);
        end

        wait_idle();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
